// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define KMP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define KMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KMP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define KMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/kmp_pkg.sv -----
// ---------------------------------------------------------------------------
// kmp_pkg
// shared constants, command codes, state and control/status types
// ---------------------------------------------------------------------------
package kmp_pkg;

  localparam int unsigned MAX_PATTERN    = 32;
  localparam int unsigned POSITION_WIDTH = 32;
  localparam int unsigned IDX_W          = $clog2(MAX_PATTERN);
  localparam int unsigned LEN_W          = $clog2(MAX_PATTERN + 1);
  localparam int unsigned MATCH_W        = 32;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CMD_W          = 2;

  // input commands
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PROBE,
    ST_CMP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_pat;
    logic restart;
    logic pos_inc;
    logic p_start;
    logic p_fall;
    logic fin_text;
    logic fin_pat;
    logic first;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_text;
    logic is_append;
    logic is_clear;
    logic len_zero;
    logic len_full;
    logic hit;
    logic p_zero;
    logic full_match;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- sv/kmp_ram.sv -----
// ---------------------------------------------------------------------------
// kmp_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module kmp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/kmp_ctrl.sv -----
// ---------------------------------------------------------------------------
// kmp_ctrl
// sequencer: decode, probe/compare loop along failure links, finish
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kmp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kmp_pkg::dp_stat_t stat,
  output kmp_pkg::dp_cmd_t  cmd
);
  import kmp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if ((stat.is_text && !stat.len_zero) ||
            (stat.is_append && !stat.len_full && !stat.len_zero)) begin
          state_nxt = ST_PROBE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PROBE: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (stat.hit) begin
          if (!(stat.is_text && stat.full_match && !stat.out_free)) begin
            state_nxt = ST_IDLE;
          end
        end else if (!stat.p_zero) begin
          state_nxt = ST_PROBE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
      end
      ST_DECODE: begin
        if (stat.is_clear) begin
          cmd.clr_pat = 1'b1;
          cmd.restart = 1'b1;
        end
        if (stat.is_append) begin
          cmd.restart = 1'b1;
          if (!stat.len_full) begin
            if (stat.len_zero) begin
              cmd.fin_pat = 1'b1;
              cmd.first   = 1'b1;
            end else begin
              cmd.p_start = 1'b1;
            end
          end
        end
        if (stat.is_text) begin
          if (stat.len_zero) begin
            cmd.pos_inc = 1'b1;
          end else begin
            cmd.p_start = 1'b1;
          end
        end
      end
      ST_CMP: begin
        if (stat.hit) begin
          if (stat.is_text) begin
            cmd.fin_text = !stat.full_match || stat.out_free;
          end else begin
            cmd.fin_pat = 1'b1;
          end
        end else if (!stat.p_zero) begin
          cmd.p_fall = 1'b1;
        end else if (stat.is_text) begin
          cmd.fin_text = 1'b1;
        end else begin
          cmd.fin_pat = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `KMP_ASSERT_NEXT(a_accept_decode, clk, rst_n, in_valid && !in_stall, state_r == ST_DECODE, "accepted item not decoded")
  `KMP_ASSERT_NEXT(a_probe_cmp, clk, rst_n, state_r == ST_PROBE, state_r == ST_CMP, "probe not followed by compare")
  `KMP_ASSERT_IMPL(a_fin_text_cmp, clk, rst_n, cmd.fin_text, state_r == ST_CMP, "text finish outside compare")

endmodule

// ----- sv/kmp_dp.sv -----
// ---------------------------------------------------------------------------
// kmp_dp
// pattern and failure stores, match state, text position, result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kmp_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [kmp_pkg::CMD_W-1:0]           in_cmd,
  input  logic [kmp_pkg::BYTE_W-1:0]          in_data_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [kmp_pkg::MATCH_W-1:0]         out_match_start,
  input  kmp_pkg::dp_cmd_t                    cmd,
  output kmp_pkg::dp_stat_t                   stat
);
  import kmp_pkg::*;

  logic [CMD_W-1:0]          cmd_r;
  logic [BYTE_W-1:0]         byte_r;
  logic [LEN_W-1:0]          len_r;
  logic [LEN_W-1:0]          bp_r;
  logic [LEN_W-1:0]          mp_r;
  logic [POSITION_WIDTH-1:0] pos_r;
  logic [IDX_W-1:0]          p_r;
  logic                      out_valid_r;
  logic [MATCH_W-1:0]        out_start_r;

  logic [LEN_W-1:0]          mp_nxt;
  logic [IDX_W-1:0]          p_nxt;
  logic [LEN_W-1:0]          start_val;
  logic [BYTE_W-1:0]         pat_rd;
  logic [LEN_W-1:0]          fail_rd;
  logic [LEN_W-1:0]          probe_k;
  logic [LEN_W-1:0]          k_fin;
  logic [POSITION_WIDTH-1:0] match_pos;
  logic                      hit;
  logic                      full_match;
  logic                      out_load;

  assign hit        = (pat_rd == byte_r);
  assign probe_k    = LEN_W'(p_r) + LEN_W'(1);
  assign full_match = hit && (probe_k == len_r);
  assign k_fin      = (cmd.first || !hit) ? '0 : probe_k;
  assign match_pos  = pos_r - POSITION_WIDTH'(len_r - LEN_W'(1));
  assign out_load   = cmd.fin_text && full_match;

  // starting probe: text resumes at match progress, append at last prefix
  assign start_val = (cmd_r == CMD_TEXT) ? mp_r : bp_r;

  always_comb begin
    p_nxt = p_r;
    if (cmd.p_start) begin
      p_nxt = (start_val >= len_r) ? '0 : start_val[IDX_W-1:0];
    end else if (cmd.p_fall) begin
      p_nxt = fail_rd[IDX_W-1:0];
    end
  end

  always_comb begin
    mp_nxt = mp_r;
    if (cmd.restart) begin
      mp_nxt = '0;
    end else if (cmd.fin_text) begin
      mp_nxt = full_match ? bp_r : k_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      bp_r        <= '0;
      mp_r        <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mp_r <= mp_nxt;
      if (cmd.clr_pat) begin
        len_r <= '0;
        bp_r  <= '0;
      end else if (cmd.fin_pat) begin
        len_r <= len_r + LEN_W'(1);
        bp_r  <= k_fin;
      end
      if (cmd.restart) begin
        pos_r <= '0;
      end else if (cmd.pos_inc || cmd.fin_text) begin
        pos_r <= pos_r + POSITION_WIDTH'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      byte_r <= in_data_byte;
    end
    if (out_load) begin
      out_start_r <= MATCH_W'(match_pos);
    end
  end

  kmp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PATTERN)
  ) u_pat_ram (
    .clk   (clk),
    .we    (cmd.fin_pat),
    .waddr (len_r[IDX_W-1:0]),
    .wdata (byte_r),
    .raddr (p_r),
    .rdata (pat_rd)
  );

  kmp_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MAX_PATTERN)
  ) u_fail_ram (
    .clk   (clk),
    .we    (cmd.fin_pat),
    .waddr (len_r[IDX_W-1:0]),
    .wdata (k_fin),
    .raddr (p_r - IDX_W'(1)),
    .rdata (fail_rd)
  );

  assign stat.is_text    = (cmd_r == CMD_TEXT);
  assign stat.is_append  = (cmd_r == CMD_APPEND);
  assign stat.is_clear   = (cmd_r == CMD_CLEAR);
  assign stat.len_zero   = (len_r == '0);
  assign stat.len_full   = (len_r >= LEN_W'(MAX_PATTERN));
  assign stat.hit        = hit;
  assign stat.p_zero     = (p_r == '0);
  assign stat.full_match = full_match;
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_match_start = out_start_r;

  `KMP_ASSERT_IMPL(a_len_range, clk, rst_n, 1'b1, len_r <= LEN_W'(MAX_PATTERN), "pattern length overflow")
  `KMP_ASSERT_IMPL(a_mp_range, clk, rst_n, 1'b1, mp_r < len_r || (mp_r == '0 && len_r == '0), "match progress out of range")
  `KMP_ASSERT_IMPL(a_bp_range, clk, rst_n, 1'b1, bp_r < len_r || (bp_r == '0 && len_r == '0), "build prefix out of range")

endmodule

// ----- sv/kmp_stream_matcher.sv -----
// ---------------------------------------------------------------------------
// kmp_stream_matcher
// streaming knuth-morris-pratt matcher with online failure table build
// ---------------------------------------------------------------------------
// clear, unused command, or text with empty pattern: decode, then back to idle
// text byte or append: decode, then a probe and a compare per step along the
//   failure chain; each probe waits on the registered read of the pattern and
//   failure rams; one item at a time
// a match result lands in the output register in the last cycle of its item
// reset: synchronous rst_n clears length, prefixes, position and valid flag
module kmp_stream_matcher (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel: one transfer per command
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [kmp_pkg::CMD_W-1:0]   in_cmd,
  input  logic [kmp_pkg::BYTE_W-1:0]  in_data_byte,
  // result channel: one transfer per complete match
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kmp_pkg::MATCH_W-1:0] out_match_start
);
  import kmp_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // controller: accepts a transfer only when idle, walks failure links
  kmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // datapath: stores, progress registers and the result register, which
  // decouples a waiting result from acceptance of the next item
  kmp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_start (out_match_start),
    .cmd             (dp_cmd),
    .stat            (dp_stat)
  );

endmodule

// ----- bench/tb_kmp_stream_matcher.sv -----
// ---------------------------------------------------------------------------
// tb_kmp_stream_matcher
// self-checking bench for the streaming knuth-morris-pratt matcher: a short
// table of hand-picked commands, then random pattern/text bursts, scored against
// typed-in results or a cycle-free predictor of the failure table and match progress,
// while the input and result channels idle and stall at several rates
// ---------------------------------------------------------------------------
module tb_kmp_stream_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  import kmp_pkg::*;

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned ITEM_TARGET    = 1400;
  // worst item walks the whole failure chain plus a stalled result, so this is loose
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 200;

  // cmd 3 has no meaning, the block must ignore it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // how a directed row is scored
  typedef enum logic [1:0] {
    CHK_PREDICT,  // whatever the predictor says
    CHK_QUIET,    // typed in: no result
    CHK_HIT       // typed in: one result at the given offset
  } check_kind_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [BYTE_W-1:0]  data;
    logic [5:0]         reps;
    check_kind_t        chk;
    logic [MATCH_W-1:0] start;
  } step_row_t;

  localparam int unsigned N_DIRECTED = 26;

  // directed table, each row sent reps times in a row
  localparam step_row_t DIRECTED [N_DIRECTED] = '{
    // empty pattern straight out of reset, then the meaningless command
    '{CMD_TEXT,   8'h00, 6'd1,  CHK_QUIET,   32'd0},
    '{CMD_UNUSED, 8'hFF, 6'd1,  CHK_QUIET,   32'd0},
    // pattern "aa": overlapping hits at 0 and 1
    '{CMD_APPEND, 8'h61, 6'd1,  CHK_QUIET,   32'd0},
    '{CMD_APPEND, 8'h61, 6'd1,  CHK_QUIET,   32'd0},
    '{CMD_TEXT,   8'h61, 6'd1,  CHK_QUIET,   32'd0},
    '{CMD_TEXT,   8'h61, 6'd1,  CHK_HIT,     32'd0},
    '{CMD_TEXT,   8'h61, 6'd1,  CHK_HIT,     32'd1},
    '{CMD_TEXT,   8'h62, 6'd1,  CHK_QUIET,   32'd0},
    // clear, then text against an empty pattern
    '{CMD_CLEAR,  8'hFF, 6'd1,  CHK_QUIET,   32'd0},
    '{CMD_TEXT,   8'h61, 6'd1,  CHK_QUIET,   32'd0},
    // extreme byte values
    '{CMD_APPEND, 8'h00, 6'd1,  CHK_QUIET,   32'd0},
    '{CMD_APPEND, 8'hFF, 6'd1,  CHK_QUIET,   32'd0},
    '{CMD_TEXT,   8'h00, 6'd1,  CHK_QUIET,   32'd0},
    '{CMD_TEXT,   8'hFF, 6'd1,  CHK_HIT,     32'd0},
    '{CMD_TEXT,   8'hFF, 6'd1,  CHK_QUIET,   32'd0},
    // append after text: pattern grows and text offsets restart
    '{CMD_APPEND, 8'h00, 6'd1,  CHK_QUIET,   32'd0},
    '{CMD_TEXT,   8'h00, 6'd1,  CHK_PREDICT, 32'd0},
    '{CMD_TEXT,   8'hFF, 6'd1,  CHK_PREDICT, 32'd0},
    '{CMD_TEXT,   8'h00, 6'd1,  CHK_PREDICT, 32'd0},
    '{CMD_TEXT,   8'hFF, 6'd1,  CHK_PREDICT, 32'd0},
    '{CMD_TEXT,   8'h00, 6'd1,  CHK_PREDICT, 32'd0},
    // fill the pattern and push one byte past capacity
    '{CMD_CLEAR,  8'h00, 6'd1,  CHK_QUIET,   32'd0},
    '{CMD_APPEND, 8'h5A, 6'd33, CHK_QUIET,   32'd0},
    '{CMD_TEXT,   8'h5A, 6'd33, CHK_PREDICT, 32'd0},
    // append to a full pattern: byte dropped, text restarted
    '{CMD_APPEND, 8'hA5, 6'd1,  CHK_QUIET,   32'd0},
    '{CMD_TEXT,   8'hA5, 6'd1,  CHK_PREDICT, 32'd0}
  };

  // dut ports, inputs all known from time zero
  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd       = CMD_UNUSED;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [MATCH_W-1:0]  out_match_start;

  // a transfer happens at a rising edge with valid high and stall low
  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  // predictor state: stored pattern, failure links, match progress
  logic [BYTE_W-1:0]         pat_mem  [MAX_PATTERN] = '{default: '0};
  logic [LEN_W-1:0]          fail_mem [MAX_PATTERN] = '{default: '0};
  logic [LEN_W-1:0]          pat_len   = '0;
  logic [LEN_W-1:0]          pre_len   = '0;
  logic [LEN_W-1:0]          progress  = '0;
  logic [POSITION_WIDTH-1:0] text_pos  = '0;

  // match offsets still owed by the dut, oldest first
  logic [MATCH_W-1:0] expected_starts [$];
  logic [MATCH_W-1:0] want_start;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned items_sent      = 0;
  int unsigned results_seen    = 0;
  int unsigned errors          = 0;

  kmp_stream_matcher DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_start (out_match_start)
  );

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // advance the predictor by one accepted command; returns 1 on a full match
  function automatic bit step_matcher(input logic [CMD_W-1:0] cmd,
                                      input logic [BYTE_W-1:0] b,
                                      output logic [MATCH_W-1:0] start);
    logic [LEN_W-1:0] k;
    logic [LEN_W-1:0] n;
    bit found;
    found = 1'b0;
    start = '0;
    case (cmd)
      CMD_APPEND: begin
        // any append restarts text counting, even when the byte is dropped
        progress = '0;
        text_pos = '0;
        if (pat_len < MAX_PATTERN) begin
          n = pat_len;
          pat_mem[IDX_W'(n)] = b;
          if (n == 0) begin
            fail_mem[0] = '0;
            pre_len = '0;
          end else begin
            // extend the longest border of the previous prefix
            k = (pre_len >= n) ? '0 : pre_len;
            while (k > 0 && pat_mem[IDX_W'(k)] != b) k = fail_mem[IDX_W'(k - 1'b1)];
            if (pat_mem[IDX_W'(k)] == b) k = k + 1'b1;
            fail_mem[IDX_W'(n)] = k;
            pre_len = k;
          end
          pat_len = n + 1'b1;
        end
      end
      CMD_TEXT: begin
        if (pat_len > 0) begin
          k = (progress >= pat_len) ? '0 : progress;
          while (k > 0 && pat_mem[IDX_W'(k)] != b) k = fail_mem[IDX_W'(k - 1'b1)];
          if (pat_mem[IDX_W'(k)] == b) k = k + 1'b1;
          if (k == pat_len) begin
            start = MATCH_W'(text_pos - POSITION_WIDTH'(pat_len) + 1'b1);
            found = 1'b1;
            // keep the border so overlapping matches are found
            k = fail_mem[IDX_W'(pat_len - 1'b1)];
          end
          progress = k;
        end
        text_pos = text_pos + 1'b1;
      end
      CMD_CLEAR: begin
        pat_len  = '0;
        pre_len  = '0;
        progress = '0;
        text_pos = '0;
      end
      default: ;
    endcase
    return found;
  endfunction

  // drive one command; entered and left just after a falling edge, so valid
  // gets exactly one assignment per edge and stays high for back-to-back items
  task automatic send_item(input logic [CMD_W-1:0]   cmd,
                           input logic [BYTE_W-1:0]  data,
                           input check_kind_t        chk = CHK_PREDICT,
                           input logic [MATCH_W-1:0] typed_start = '0);
    logic [MATCH_W-1:0] start;
    bit hit;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_data_byte <= data;
    do @(posedge clk); while (in_stall !== 1'b0);
    // transfer taken at this edge
    hit = step_matcher(cmd, data, start);
    case (chk)
      CHK_PREDICT: if (hit) expected_starts = {expected_starts, start};
      CHK_HIT:     expected_starts = {expected_starts, typed_start};
      default: ;
    endcase
    if (cmd != CMD_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // mostly pattern-like text so matches, overlaps and fallbacks happen often
  function automatic logic [BYTE_W-1:0] alpha_byte(input logic [BYTE_W-1:0] base,
                                                   input int unsigned n);
    if ($urandom_range(0, 99) < 85) return base + BYTE_W'($urandom_range(0, n - 1));
    return BYTE_W'($urandom);
  endfunction

  // one burst: a fresh pattern and text, an extension mid-stream, or noise
  task automatic random_burst();
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] pat_copy [$];
    logic [BYTE_W-1:0] b;
    int unsigned alpha_n;
    int unsigned pat_n;
    int unsigned kind;
    kind    = $urandom_range(0, 99);
    base    = BYTE_W'($urandom);
    alpha_n = $urandom_range(1, 3);
    if (kind < 70) begin
      if ($urandom_range(0, 9) < 7) send_item(CMD_CLEAR, BYTE_W'($urandom));
      // mostly short patterns, now and then a long one that can run past capacity
      pat_n = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 4);
      repeat (pat_n) begin
        b = base + BYTE_W'($urandom_range(0, alpha_n - 1));
        pat_copy = {pat_copy, b};
        send_item(CMD_APPEND, b);
      end
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 1) == 0) begin
          // replay the pattern with the odd corrupted byte
          foreach (pat_copy[i])
            send_item(CMD_TEXT, ($urandom_range(0, 19) == 0) ? BYTE_W'($urandom) : pat_copy[i]);
        end else begin
          repeat ($urandom_range(1, 6)) send_item(CMD_TEXT, alpha_byte(base, alpha_n));
        end
      end
    end else if (kind < 85) begin
      send_item(CMD_APPEND, alpha_byte(base, alpha_n));
      repeat ($urandom_range(2, 10)) send_item(CMD_TEXT, alpha_byte(base, alpha_n));
    end else begin
      repeat ($urandom_range(1, 4)) send_item(CMD_W'($urandom_range(0, 3)), BYTE_W'($urandom));
    end
  endtask

  // result scoreboard: every result against the oldest owed offset
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (expected_starts.size() == 0) begin
        $display("%0t: unexpected match result, expected none, got %0d",
                 $time, out_match_start);
        errors++;
      end else begin
        want_start = expected_starts.pop_front();
        if (out_match_start !== want_start) begin
          $display("%0t: match_start mismatch, expected %0d, got %0d",
                   $time, want_start, out_match_start);
          errors++;
        end
      end
    end
  end

  // watchdog: too long without any transfer on either channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (in_fire || out_fire) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results still owed",
             $time, WATCHDOG_LIMIT, expected_starts.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, no idling
    foreach (DIRECTED[i])
      repeat (DIRECTED[i].reps)
        send_item(DIRECTED[i].cmd, DIRECTED[i].data, DIRECTED[i].chk, DIRECTED[i].start);

    // random bursts over four idling phases
    while (items_sent < ITEM_TARGET) begin
      phase = (items_sent * 4) / ITEM_TARGET;
      case (phase)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 79; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin sender_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      random_burst();
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;

    // drain owed results, then watch for strays
    while (expected_starts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_starts.size() != 0) begin
      $display("%0t: %0d match results never arrived", $time, expected_starts.size());
      errors++;
    end

    $display("sent %0d commands: directed table, then pattern/text bursts and noise",
             items_sent);
    $display("checked %0d match results over four idling phases, %0d mismatches",
             results_seen, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
